### hw/rtl/stq_pkg.sv
// Shared types and codes for the sorted timer queue.
package stq_pkg;

   localparam int TIME_W      = 48;
   localparam int ID_W        = 8;
   localparam int MAX_RESULTS = 16;

   localparam logic       FUNC_INSERT = 1'b0;
   localparam logic       FUNC_POST   = 1'b1;

   localparam logic [1:0] ST_INSERTED = 2'd0;
   localparam logic [1:0] ST_DROPPED  = 2'd1;
   localparam logic [1:0] ST_EXPIRED  = 2'd2;
   localparam logic [1:0] ST_NONE     = 2'd3;

   typedef struct packed {
      logic              func;
      logic [ID_W-1:0]   msg_id;
      logic [TIME_W-1:0] time_value;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic              became_head;
      logic [ID_W-1:0]   out_id;
      logic [TIME_W-1:0] out_expiry;
      logic              last;
      logic              head_valid;
      logic [TIME_W-1:0] head_expiry;
   } rsp_type;

   typedef struct packed {
      logic [TIME_W-1:0] expiry;
      logic [ID_W-1:0]   id;
   } slot_type;

   // Command and key broadcast to every cell.
   typedef struct packed {
      logic              insert;
      logic              mark;
      logic              shift;
      logic [TIME_W-1:0] key_time;
      logic [ID_W-1:0]   key_id;
   } cell_bus_type;

endpackage

### hw/rtl/stq_cell.sv
// One queue cell: holds a timer slot and its expired mark.
module stq_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  stq_pkg::cell_bus_type bus,
   input  stq_pkg::slot_type     prev_slot,
   input  logic                  prev_le,
   input  stq_pkg::slot_type     next_slot,
   input  logic                  next_mark,
   input  logic                  valid,
   input  logic                  mark_en,
   output stq_pkg::slot_type     slot_out,
   output logic                  le,
   output logic                  mark_out,
   output logic                  mark_next
);

   stq_pkg::slot_type slot_ff, slot_in;
   logic              mark_ff, mark_in;

   assign le        = valid && (slot_ff.expiry <= bus.key_time);
   assign mark_next = mark_en && valid && (slot_ff.expiry < bus.key_time);
   assign slot_out  = slot_ff;
   assign mark_out  = mark_ff;

   always_comb begin
      slot_in = slot_ff;
      mark_in = mark_ff;
      if (bus.insert) begin
         // keep entries that expire no later than the new one
         if (!le) begin
            if (prev_le) begin
               slot_in.expiry = bus.key_time;
               slot_in.id     = bus.key_id;
            end else begin
               slot_in = prev_slot;
            end
         end
      end else if (bus.mark) begin
         mark_in = mark_next;
      end else if (bus.shift) begin
         slot_in = next_slot;
         mark_in = next_mark;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ff <= 1'b0;
      end else begin
         mark_ff <= mark_in;
      end
   end

endmodule

### hw/rtl/sorted_timer_queue_top.sv
// Sorted timer queue: a chain of DEPTH cells kept in ascending expiry order.
// Insert: the compare-and-shift step across the cell chain runs in the EXEC state, and the result
//   is loaded into the output register in the INS_OUT state; a new request is taken only after that.
// Post: n expired entries leave one per cycle from cell 0, while the output is free, after a marking
//   step in the EXEC state; a new request is taken only after the last result is loaded.
// Reset clears the occupancy count, the marks and the control state; slots hold stale data.
module sorted_timer_queue_top #(
   parameter int DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  stq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output stq_pkg::rsp_type rsp_data
);

   localparam int COUNT_W = $clog2(DEPTH + 1);

   localparam logic [1:0] S_IDLE    = 2'd0;
   localparam logic [1:0] S_EXEC    = 2'd1;
   localparam logic [1:0] S_INS_OUT = 2'd2;
   localparam logic [1:0] S_DRAIN   = 2'd3;

   logic [1:0]                   state_ff, state_in;
   logic [COUNT_W-1:0]           occ_ff, occ_in;
   logic                         func_ff;
   logic [stq_pkg::ID_W-1:0]     key_id_ff;
   logic [stq_pkg::TIME_W-1:0]   key_time_ff;
   logic [1:0]                   status_ff, status_in;
   logic                         bh_ff, bh_in;
   logic                         hv_ff, hv_in;
   logic [stq_pkg::TIME_W-1:0]   head_ff, head_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   stq_pkg::rsp_type             rsp_ff, rsp_in;

   stq_pkg::cell_bus_type        bus;
   stq_pkg::slot_type            slot_arr [DEPTH];
   logic [DEPTH-1:0]             le_vec, mark_vec, mark_nx_vec, valid_vec, cand_vec;
   logic [stq_pkg::TIME_W-1:0]   head_sel;
   logic                         out_free, full, req_fire;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign full      = (occ_ff == COUNT_W'(DEPTH));
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign bus.insert   = (state_ff == S_EXEC) && (func_ff == stq_pkg::FUNC_INSERT) && !full;
   assign bus.mark     = (state_ff == S_EXEC) && (func_ff == stq_pkg::FUNC_POST);
   assign bus.shift    = (state_ff == S_DRAIN) && out_free && mark_vec[0];
   assign bus.key_time = key_time_ff;
   assign bus.key_id   = key_id_ff;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      stq_pkg::slot_type prev_slot, next_slot;
      logic              prev_le, next_mark;

      assign valid_vec[i] = (COUNT_W'(i) < occ_ff);

      if (i == 0) begin : g_first
         assign prev_slot = slot_arr[0];
         assign prev_le   = 1'b1;
      end else begin : g_mid
         assign prev_slot = slot_arr[i-1];
         assign prev_le   = le_vec[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign next_slot = slot_arr[i];
         assign next_mark = 1'b0;
      end else begin : g_inner
         assign next_slot = slot_arr[i+1];
         assign next_mark = mark_vec[i+1];
      end

      stq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .bus       (bus),
         .prev_slot (prev_slot),
         .prev_le   (prev_le),
         .next_slot (next_slot),
         .next_mark (next_mark),
         .valid     (valid_vec[i]),
         .mark_en   (i < stq_pkg::MAX_RESULTS),
         .slot_out  (slot_arr[i]),
         .le        (le_vec[i]),
         .mark_out  (mark_vec[i]),
         .mark_next (mark_nx_vec[i])
      );
   end

   // The new head after a post is the first live cell that stays unmarked.
   assign cand_vec = valid_vec & ~mark_nx_vec & {mark_nx_vec[DEPTH-2:0], 1'b1};

   always_comb begin
      head_sel = '0;
      for (int i = 0; i < DEPTH; i++) begin
         head_sel = head_sel | ({stq_pkg::TIME_W{cand_vec[i]}} & slot_arr[i].expiry);
      end
   end

   always_comb begin
      state_in     = state_ff;
      occ_in       = occ_ff;
      status_in    = status_ff;
      bh_in        = bh_ff;
      hv_in        = hv_ff;
      head_in      = head_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (func_ff == stq_pkg::FUNC_INSERT) begin
               if (full) begin
                  status_in = stq_pkg::ST_DROPPED;
                  bh_in     = 1'b0;
               end else begin
                  status_in = stq_pkg::ST_INSERTED;
                  bh_in     = !le_vec[0];
                  occ_in    = occ_ff + COUNT_W'(1);
               end
               state_in = S_INS_OUT;
            end else begin
               hv_in    = |cand_vec;
               head_in  = head_sel;
               state_in = S_DRAIN;
            end
         end
         S_INS_OUT: begin
            if (out_free) begin
               rsp_in.status      = status_ff;
               rsp_in.became_head = bh_ff;
               rsp_in.out_id      = '0;
               rsp_in.out_expiry  = '0;
               rsp_in.last        = 1'b1;
               rsp_in.head_valid  = valid_vec[0];
               rsp_in.head_expiry = valid_vec[0] ? slot_arr[0].expiry : '0;
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end
         end
         S_DRAIN: begin
            if (out_free) begin
               rsp_in.became_head = 1'b0;
               rsp_in.head_valid  = hv_ff;
               rsp_in.head_expiry = head_ff;
               rsp_valid_in       = 1'b1;
               if (mark_vec[0]) begin
                  // emit the head and advance the chain
                  rsp_in.status     = stq_pkg::ST_EXPIRED;
                  rsp_in.out_id     = slot_arr[0].id;
                  rsp_in.out_expiry = slot_arr[0].expiry;
                  rsp_in.last       = !mark_vec[1];
                  occ_in            = occ_ff - COUNT_W'(1);
                  if (!mark_vec[1]) begin
                     state_in = S_IDLE;
                  end
               end else begin
                  rsp_in.status     = stq_pkg::ST_NONE;
                  rsp_in.out_id     = '0;
                  rsp_in.out_expiry = '0;
                  rsp_in.last       = 1'b1;
                  state_in          = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         func_ff     <= req_data.func;
         key_id_ff   <= req_data.msg_id;
         key_time_ff <= req_data.time_value;
      end
      status_ff <= status_in;
      bh_ff     <= bh_in;
      hv_ff     <= hv_in;
      head_ff   <= head_in;
      rsp_ff    <= rsp_in;
   end

   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= COUNT_W'(DEPTH))
      else $error("occupancy beyond depth");

   a_mark_prefix: assert property (@(posedge clock) disable iff (reset)
      $onehot({1'b0, mark_vec} + {{DEPTH{1'b0}}, 1'b1}))
      else $error("expired marks not a prefix of the chain");

   a_mark_live: assert property (@(posedge clock) disable iff (reset)
      (mark_vec & ~valid_vec) == '0)
      else $error("mark set on an empty cell");

   a_drain_expired: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAIN && out_free && mark_vec[0]) |-> (slot_arr[0].expiry < key_time_ff))
      else $error("emitted entry not expired");

   a_idle_no_marks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (mark_vec == '0))
      else $error("marks left after post");

endmodule

### bench/tb.sv
// Self-checking testbench for the sorted timer queue: directed plan, then random traffic.
`timescale 1ns / 1ps

module tb;

   localparam int DEPTH      = 16;
   localparam int PLAN_ROWS  = 25;
   localparam int RAND_ITEMS = 25;
   localparam int CYCLE_CAP  = 300000;
   localparam logic [stq_pkg::TIME_W-1:0] T_MAX = '1;

   typedef struct {
      stq_pkg::req_type item;
      bit               typed;
      stq_pkg::rsp_type want;
   } step_row_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   stq_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   stq_pkg::rsp_type rsp_data;

   // timer store as the block should hold it
   logic [stq_pkg::TIME_W-1:0] q_expiry [DEPTH];
   logic [stq_pkg::ID_W-1:0]   q_id     [DEPTH];
   int                         q_count = 0;

   stq_pkg::rsp_type step_out[$];
   stq_pkg::rsp_type due_results[$];
   stq_pkg::rsp_type want_rsp;
   step_row_type     plan [PLAN_ROWS];

   int sender_idle_pct = 35;
   int rcv_stall_pct   = 84;
   int err_count       = 0;
   int items_sent      = 0;
   int results_seen    = 0;
   int expired_seen    = 0;
   int dropped_seen    = 0;
   int empty_posts     = 0;
   int cycles          = 0;

   sorted_timer_queue_top #(.DEPTH(DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_CAP) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  due_results.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Apply one item to the timer store and leave its results in step_out.
   function automatic void apply_timer_op(input stq_pkg::req_type item);
      stq_pkg::rsp_type r;
      int               pos;
      int               n;
      int               i;
      step_out.delete();
      r = '0;
      if (item.func == stq_pkg::FUNC_INSERT) begin
         r.last = 1'b1;
         if (q_count >= DEPTH) begin
            r.status = stq_pkg::ST_DROPPED;
         end else begin
            pos = 0;
            while (pos < q_count && q_expiry[pos] <= item.time_value) pos++;
            for (i = q_count; i > pos; i--) begin
               q_expiry[i] = q_expiry[i-1];
               q_id[i]     = q_id[i-1];
            end
            q_expiry[pos] = item.time_value;
            q_id[pos]     = item.msg_id;
            q_count++;
            r.status      = stq_pkg::ST_INSERTED;
            r.became_head = (pos == 0);
         end
         step_out.insert(step_out.size(), r);
      end else begin
         n = 0;
         while (n < q_count && n < stq_pkg::MAX_RESULTS &&
                q_expiry[n] < item.time_value) begin
            r            = '0;
            r.status     = stq_pkg::ST_EXPIRED;
            r.out_id     = q_id[n];
            r.out_expiry = q_expiry[n];
            step_out.insert(step_out.size(), r);
            n++;
         end
         if (n == 0) begin
            r        = '0;
            r.status = stq_pkg::ST_NONE;
            r.last   = 1'b1;
            step_out.insert(step_out.size(), r);
         end else begin
            step_out[n-1].last = 1'b1;
            for (i = n; i < q_count; i++) begin
               q_expiry[i-n] = q_expiry[i];
               q_id[i-n]     = q_id[i];
            end
            q_count -= n;
         end
      end
      foreach (step_out[k]) begin
         step_out[k].head_valid  = (q_count > 0);
         step_out[k].head_expiry = (q_count > 0) ? q_expiry[0] : '0;
      end
   endfunction

   // Hold the item on the channel until it is taken, idling beforehand at random.
   task automatic send_item(input stq_pkg::req_type item);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic wait_drained();
      while (due_results.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rcv_stall_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (due_results.size() == 0) begin
            $error("item with no result expected: status %0d id %0d", rsp_data.status,
                   rsp_data.out_id);
            err_count++;
         end else begin
            want_rsp = due_results.pop_front();
            if (rsp_data.status !== want_rsp.status) begin
               $error("status: expected %0d, got %0d", want_rsp.status, rsp_data.status);
               err_count++;
            end
            if (rsp_data.became_head !== want_rsp.became_head) begin
               $error("became_head: expected %0d, got %0d", want_rsp.became_head,
                      rsp_data.became_head);
               err_count++;
            end
            if (rsp_data.out_id !== want_rsp.out_id) begin
               $error("out_id: expected %0d, got %0d", want_rsp.out_id, rsp_data.out_id);
               err_count++;
            end
            if (rsp_data.out_expiry !== want_rsp.out_expiry) begin
               $error("out_expiry: expected %0d, got %0d", want_rsp.out_expiry,
                      rsp_data.out_expiry);
               err_count++;
            end
            if (rsp_data.last !== want_rsp.last) begin
               $error("last: expected %0d, got %0d", want_rsp.last, rsp_data.last);
               err_count++;
            end
            if (rsp_data.head_valid !== want_rsp.head_valid) begin
               $error("head_valid: expected %0d, got %0d", want_rsp.head_valid,
                      rsp_data.head_valid);
               err_count++;
            end
            if (rsp_data.head_expiry !== want_rsp.head_expiry) begin
               $error("head_expiry: expected %0d, got %0d", want_rsp.head_expiry,
                      rsp_data.head_expiry);
               err_count++;
            end
            if (want_rsp.status == stq_pkg::ST_EXPIRED) expired_seen++;
            if (want_rsp.status == stq_pkg::ST_DROPPED) dropped_seen++;
            if (want_rsp.status == stq_pkg::ST_NONE)    empty_posts++;
         end
      end
   end

   initial begin
      stq_pkg::req_type           item;
      int                         pick;
      int                         ins_pct;
      logic [stq_pkg::TIME_W-1:0] sim_now;

      // directed plan; typed rows carry their single result
      foreach (plan[i]) begin
         plan[i].typed = 1'b0;
         plan[i].want  = '0;
         plan[i].item  = '0;
      end
      plan[0].item  = '{func: stq_pkg::FUNC_POST, msg_id: '0, time_value: '0};
      plan[0].typed = 1'b1;
      plan[0].want  = '{status: stq_pkg::ST_NONE, last: 1'b1, default: '0};
      plan[1].item  = '{func: stq_pkg::FUNC_POST, msg_id: 8'hFF, time_value: T_MAX};
      plan[1].typed = 1'b1;
      plan[1].want  = '{status: stq_pkg::ST_NONE, last: 1'b1, default: '0};
      plan[2].item  = '{func: stq_pkg::FUNC_INSERT, msg_id: 8'h00, time_value: T_MAX};
      plan[2].typed = 1'b1;
      plan[2].want  = '{status: stq_pkg::ST_INSERTED, became_head: 1'b1, last: 1'b1,
                        head_valid: 1'b1, head_expiry: T_MAX, default: '0};
      plan[3].item  = '{func: stq_pkg::FUNC_INSERT, msg_id: 8'hFF, time_value: '0};
      plan[3].typed = 1'b1;
      plan[3].want  = '{status: stq_pkg::ST_INSERTED, became_head: 1'b1, last: 1'b1,
                        head_valid: 1'b1, default: '0};
      // equal expiry goes behind the earlier one
      plan[4].item  = '{func: stq_pkg::FUNC_INSERT, msg_id: 8'h5A, time_value: '0};
      plan[4].typed = 1'b1;
      plan[4].want  = '{status: stq_pkg::ST_INSERTED, last: 1'b1, head_valid: 1'b1,
                        default: '0};
      plan[5].item  = '{func: stq_pkg::FUNC_INSERT, msg_id: 8'hA5, time_value: 48'd1000};
      // expiry equal to the clock does not leave
      plan[6].item  = '{func: stq_pkg::FUNC_POST, msg_id: '0, time_value: '0};
      plan[6].typed = 1'b1;
      plan[6].want  = '{status: stq_pkg::ST_NONE, last: 1'b1, head_valid: 1'b1,
                        default: '0};
      plan[7].item  = '{func: stq_pkg::FUNC_POST, msg_id: '0, time_value: 48'd1};
      // fill up to the full store with repeated expiries
      for (int k = 0; k < 14; k++)
         plan[8+k].item = '{func: stq_pkg::FUNC_INSERT, msg_id: 8'(8'h10 + 17 * k),
                            time_value: 48'(1000 + 100 * (k % 7))};
      plan[22].item  = '{func: stq_pkg::FUNC_INSERT, msg_id: 8'h33, time_value: 48'd5};
      plan[22].typed = 1'b1;
      plan[22].want  = '{status: stq_pkg::ST_DROPPED, last: 1'b1, head_valid: 1'b1,
                         head_expiry: 48'd1000, default: '0};
      plan[23].item  = '{func: stq_pkg::FUNC_POST, msg_id: '0, time_value: T_MAX};
      plan[24].item  = '{func: stq_pkg::FUNC_POST, msg_id: '0, time_value: T_MAX};
      plan[24].typed = 1'b1;
      plan[24].want  = '{status: stq_pkg::ST_NONE, last: 1'b1, head_valid: 1'b1,
                         head_expiry: T_MAX, default: '0};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         send_item(plan[i].item);
         apply_timer_op(plan[i].item);
         if (plan[i].typed) due_results.insert(due_results.size(), plan[i].want);
         else foreach (step_out[k]) due_results.insert(due_results.size(), step_out[k]);
      end

      sim_now = 48'(2000 + $urandom_range(5000));
      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin sender_idle_pct = 35; rcv_stall_pct = 84; ins_pct = 55; end
            1: begin sender_idle_pct = 84; rcv_stall_pct = 35; ins_pct = 75; end
            default: begin sender_idle_pct = 0; rcv_stall_pct = 0; ins_pct = 50; end
         endcase
         for (int k = 0; k < RAND_ITEMS; k++) begin
            pick        = $urandom_range(99);
            item.msg_id = 8'($urandom_range(255));
            if (pick < ins_pct) begin
               item.func       = stq_pkg::FUNC_INSERT;
               item.time_value = sim_now + 48'($urandom_range(300));
            end else if (pick < 92) begin
               sim_now         = sim_now + 48'($urandom_range(200));
               item.func       = stq_pkg::FUNC_POST;
               item.time_value = sim_now;
            end else if (pick < 96) begin
               item.func       = stq_pkg::FUNC_INSERT;
               item.time_value = 48'({$urandom, $urandom});
            end else begin
               item.func       = stq_pkg::FUNC_POST;
               item.time_value = $urandom_range(1) ? T_MAX : 48'({$urandom, $urandom});
            end
            send_item(item);
            apply_timer_op(item);
            foreach (step_out[k2]) due_results.insert(due_results.size(), step_out[k2]);
         end
         // hold the sender until the queue of results is empty
         req_valid <= 1'b0;
         wait_drained();
      end

      wait_drained();
      repeat (12) @(posedge clock);
      $display("Sent %0d items (%0d from the directed plan); %0d results checked.",
               items_sent, PLAN_ROWS, results_seen);
      $display("Saw %0d expired timers, %0d drops on a full queue, %0d empty posts.",
               expired_seen, dropped_seen, empty_posts);
      if (err_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches", err_count);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/stq_pkg.sv
hw/rtl/stq_cell.sv
hw/rtl/sorted_timer_queue_top.sv
bench/tb.sv
